FILE: sv/sliding_trend_slope_alarm_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the trend slope alarm
// Concurrent checks that vanish when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef SLIDING_TREND_SLOPE_ALARM_ASSERT_SVH
`define SLIDING_TREND_SLOPE_ALARM_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define STSA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every rising edge, reset included.
`define STSA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define STSA_ASSERT(lbl, clk, rst_n, prop, msg)
`define STSA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: sv/stsa_pkg.sv
// ---------------------------------------------------------------------------
// stsa_pkg
// Shared constants of the sliding trend slope alarm.
// ---------------------------------------------------------------------------
`default_nettype none

package stsa_pkg;

    // Window length at the default build.
    localparam int WINDOW_DEFAULT = 12;

    // Field widths.
    localparam int ACCEL_W   = 16;
    localparam int TEMP_W    = 8;
    localparam int TREND_W   = 25;
    localparam int TTREND_W  = 17;
    localparam int LEVEL_W   = 2;
    localparam int ZLIM_W    = 24;
    localparam int TLIM_W    = 16;

    // One stored sample: x, y, z, temperature from the lowest bit up.
    localparam int SAMPLE_W  = 3 * ACCEL_W + TEMP_W;
    localparam int S_TDATA_W = SAMPLE_W;
    localparam int M_DATA_W  = 3 * TREND_W + TTREND_W + LEVEL_W;
    localparam int M_TDATA_W = ((M_DATA_W + 7) / 8) * 8;

    // Configuration port.
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = ZLIM_W;
    localparam logic [CFG_ADDR_W-1:0] CFG_Z_LIMIT    = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TEMP_LIMIT = 1'd1;

    localparam logic [ZLIM_W-1:0] Z_LIMIT_RESET    = 24'd8580;
    localparam logic [TLIM_W-1:0] TEMP_LIMIT_RESET = 16'd2574;

    // Alert codes.
    localparam logic [LEVEL_W-1:0] LVL_NOMINAL = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_WARNING = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_SHOCK   = 2'd2;

endpackage

`default_nettype wire

FILE: sv/sliding_trend_slope_alarm.sv
// ---------------------------------------------------------------------------
// sliding_trend_slope_alarm
// Least-squares trend of four sensor channels over a sliding window,
// with a shock / trend alert level.
// ---------------------------------------------------------------------------
//
//  channel   | ports                         | payload
//  ----------+-------------------------------+------------------------------
//  sample in | s_tvalid s_tready s_tdata/user| x, y, z, temperature; shock
//  result    | m_tvalid m_tready m_tdata/user| trends x y z temp, level; valid
//  config    | cfg_we cfg_addr cfg_wdata     | z_trend_limit, temp_trend_limit
//
//  A word that still fills the window goes straight to the done step.
//  A word on a full window makes one pass over the window memory, one entry
//  read per cycle, through four MACs, then a drain step and the done step.
//  In the done step, once the output register is free, the result enters it
//  and the input turns ready again on the same edge.
//  One sample is in work at a time; a finished result waits in the output
//  register and the next sample is accepted meanwhile.
//  Reset (aresetn low, synchronous) empties the window and restores the limits.
//  A stalled result holds the block in its last step until m_tready.
//
`default_nettype none

module sliding_trend_slope_alarm
    import stsa_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // sample words
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // accel_x, accel_y, accel_z, temperature
    input  wire logic                  s_tuser,   // shock
    // result words
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // trend_x, trend_y, trend_z, trend_temp,
                                                  // alarm_level, zero pad
    output logic                       m_tuser,   // slope_valid
    // configuration writes
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

`include "sliding_trend_slope_alarm_assert.svh"

    // Derived sizes.
    localparam int LOG_W   = $clog2(WINDOW);
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int HALF    = WINDOW * (WINDOW - 1) / 2;
    localparam int COEF_W  = 2 * LOG_W + 1;
    // |sum| < WINDOW^3 * 2^14; keep at least one bit above the widest field.
    localparam int ACC_MIN = 3 * LOG_W + 15;
    localparam int ACC_W   = (ACC_MIN > TREND_W + 1) ? ACC_MIN : TREND_W + 1;

    localparam logic [LOG_W-1:0]         LAST_IDX   = LOG_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0]         FULL_CNT   = CNT_W'(WINDOW);
    localparam logic signed [COEF_W-1:0] COEF_START = COEF_W'(-HALF);
    localparam logic signed [COEF_W-1:0] COEF_STEP  = COEF_W'(WINDOW);

    // Sequencer codes.
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    // Window memory: one row holds all four channels of a sample.
    logic [SAMPLE_W-1:0] win_mem [WINDOW];
    logic [SAMPLE_W-1:0] rd_data_reg;

    // Control state.
    logic [1:0]        state_reg,   state_next;
    logic [CNT_W-1:0]  fill_reg,    fill_next;
    logic [LOG_W-1:0]  head_reg,    head_next;     // oldest entry once full
    logic [LOG_W-1:0]  rd_addr_reg, rd_addr_next;
    logic [LOG_W-1:0]  issue_reg,   issue_next;
    logic              mac_en_reg,  mac_en_next;
    logic              m_valid_reg, m_valid_next;
    logic [ZLIM_W-1:0] zlim_reg,    zlim_next;
    logic [TLIM_W-1:0] tlim_reg,    tlim_next;

    // Work payload.
    logic                     shock_reg,  shock_next;
    logic                     valid_reg,  valid_next;
    logic signed [COEF_W-1:0] coef_reg,   coef_next;
    logic signed [ACC_W-1:0]  acc_x_reg,  acc_x_next;
    logic signed [ACC_W-1:0]  acc_y_reg,  acc_y_next;
    logic signed [ACC_W-1:0]  acc_z_reg,  acc_z_next;
    logic signed [ACC_W-1:0]  acc_t_reg,  acc_t_next;

    // Output payload.
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic                 m_user_reg, m_user_next;

    logic                        s_accept;
    logic                        full;
    logic                        rd_en;
    logic [LOG_W-1:0]            wr_addr;
    logic [LOG_W-1:0]            head_inc;
    logic signed [ACCEL_W-1:0]   rd_x, rd_y, rd_z;
    logic signed [TEMP_W-1:0]    rd_t;
    logic signed [ACCEL_W+COEF_W-1:0] prod_x, prod_y, prod_z;
    logic signed [TEMP_W+COEF_W-1:0]  prod_t;
    logic [LEVEL_W-1:0]          level;
    logic                        warn;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign full     = (fill_reg == FULL_CNT);
    assign rd_en    = (state_reg == ST_RUN);
    assign wr_addr  = full ? head_reg : fill_reg[LOG_W-1:0];
    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // Unpack the row read last cycle and weight it by its position.
    assign rd_x   = $signed(rd_data_reg[ACCEL_W-1:0]);
    assign rd_y   = $signed(rd_data_reg[2*ACCEL_W-1:ACCEL_W]);
    assign rd_z   = $signed(rd_data_reg[3*ACCEL_W-1:2*ACCEL_W]);
    assign rd_t   = $signed(rd_data_reg[SAMPLE_W-1:3*ACCEL_W]);
    assign prod_x = rd_x * coef_reg;
    assign prod_y = rd_y * coef_reg;
    assign prod_z = rd_z * coef_reg;
    assign prod_t = rd_t * coef_reg;

    // Alert: shock wins, then a trend above its limit on a full window.
    assign warn = valid_reg &&
                  ((acc_z_reg > $signed(ACC_W'(zlim_reg))) ||
                   (acc_t_reg > $signed(ACC_W'(tlim_reg))));
    assign level = shock_reg ? LVL_SHOCK : (warn ? LVL_WARNING : LVL_NOMINAL);

    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        head_next    = head_reg;
        rd_addr_next = rd_addr_reg;
        issue_next   = issue_reg;
        mac_en_next  = rd_en;
        m_valid_next = m_valid_reg;
        zlim_next    = zlim_reg;
        tlim_next    = tlim_reg;
        shock_next   = shock_reg;
        valid_next   = valid_reg;
        coef_next    = coef_reg;
        acc_x_next   = acc_x_reg;
        acc_y_next   = acc_y_reg;
        acc_z_next   = acc_z_reg;
        acc_t_next   = acc_t_reg;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;

        // Drop the result once the consumer takes it.
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_we) begin
            case (cfg_addr)
                CFG_Z_LIMIT:    zlim_next = cfg_wdata[ZLIM_W-1:0];
                CFG_TEMP_LIMIT: tlim_next = cfg_wdata[TLIM_W-1:0];
                default: ;
            endcase
        end

        // Accumulate one window entry per cycle; the coefficient steps by WINDOW.
        if (mac_en_reg) begin
            acc_x_next = acc_x_reg + ACC_W'(prod_x);
            acc_y_next = acc_y_reg + ACC_W'(prod_y);
            acc_z_next = acc_z_reg + ACC_W'(prod_z);
            acc_t_next = acc_t_reg + ACC_W'(prod_t);
            coef_next  = coef_reg + COEF_STEP;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    shock_next = s_tuser;
                    valid_next = full;
                    coef_next  = COEF_START;
                    acc_x_next = '0;
                    acc_y_next = '0;
                    acc_z_next = '0;
                    acc_t_next = '0;
                    if (full) begin
                        // Overwrite the oldest row, then sweep from the new oldest.
                        head_next    = head_inc;
                        rd_addr_next = head_inc;
                        issue_next   = '0;
                        state_next   = ST_RUN;
                    end else begin
                        fill_next  = fill_reg + 1'b1;
                        state_next = ST_DONE;
                    end
                end
            end
            ST_RUN: begin
                rd_addr_next = (rd_addr_reg == LAST_IDX) ? '0 : rd_addr_reg + 1'b1;
                issue_next   = issue_reg + 1'b1;
                if (issue_reg == LAST_IDX) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // Hold until the output register is free.
                if (!m_valid_reg || m_tready) begin
                    m_data_next = M_TDATA_W'({level,
                                              acc_t_reg[TTREND_W-1:0],
                                              acc_z_reg[TREND_W-1:0],
                                              acc_y_reg[TREND_W-1:0],
                                              acc_x_reg[TREND_W-1:0]});
                    m_user_next  = valid_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Window memory: write on accept, registered read during the sweep.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            win_mem[wr_addr] <= {s_tdata[SAMPLE_W-1:0]};
        end
        if (rd_en) begin
            rd_data_reg <= win_mem[rd_addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            head_reg    <= '0;
            rd_addr_reg <= '0;
            issue_reg   <= '0;
            mac_en_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            zlim_reg    <= Z_LIMIT_RESET;
            tlim_reg    <= TEMP_LIMIT_RESET;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            head_reg    <= head_next;
            rd_addr_reg <= rd_addr_next;
            issue_reg   <= issue_next;
            mac_en_reg  <= mac_en_next;
            m_valid_reg <= m_valid_next;
            zlim_reg    <= zlim_next;
            tlim_reg    <= tlim_next;
        end
    end

    always_ff @(posedge aclk) begin
        shock_reg  <= shock_next;
        valid_reg  <= valid_next;
        coef_reg   <= coef_next;
        acc_x_reg  <= acc_x_next;
        acc_y_reg  <= acc_y_next;
        acc_z_reg  <= acc_z_next;
        acc_t_reg  <= acc_t_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    // Checks.
    `STSA_ASSERT(a_fill_bound, aclk, aresetn, fill_reg <= FULL_CNT, "fill count beyond window")
    `STSA_ASSERT(a_head_fill, aclk, aresetn, !full |-> head_reg == '0, "head moved while filling")
    `STSA_ASSERT(a_full_sweep, aclk, aresetn, (s_accept && full) |=> state_reg == ST_RUN, "full window word skipped the sweep")
    `STSA_ASSERT(a_valid_full, aclk, aresetn, (m_valid_reg && m_user_reg) |-> full, "slope valid before window full")
    `STSA_ASSERT(a_mac_follows, aclk, aresetn, mac_en_reg |-> $past(state_reg) == ST_RUN, "accumulate without a read")

endmodule

`default_nettype wire

FILE: sim/sliding_trend_slope_alarm_test.sv
// ----------------------------------------------------------------------------
// Trend slope alarm testbench
// Streams sensor samples into the block and checks every result word against
// an in-bench window model: exact least-squares trend numerators, the
// filling/sliding window behavior and the shock/trend alert decision, under
// several limit settings and random backpressure on both channels.
// ----------------------------------------------------------------------------
module sliding_trend_slope_alarm_test
    import stsa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 10;
    localparam int WIN          = WINDOW_DEFAULT;
    localparam int POS_MID      = WIN * (WIN - 1) / 2;   // sum of positions 0..WIN-1
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 400000;

    // Result word layout, lowest bit up.
    localparam int TX_LO = 0;
    localparam int TY_LO = TREND_W;
    localparam int TZ_LO = 2 * TREND_W;
    localparam int TT_LO = 3 * TREND_W;
    localparam int LV_LO = 3 * TREND_W + TTREND_W;

    localparam int CH_X = 0;
    localparam int CH_Y = 1;
    localparam int CH_Z = 2;
    localparam int CH_T = 3;

    // Sample word, first member in the highest bits so the shock flag sits at bit 0.
    typedef struct packed {
        logic signed [TEMP_W-1:0]  temp;
        logic signed [ACCEL_W-1:0] az;
        logic signed [ACCEL_W-1:0] ay;
        logic signed [ACCEL_W-1:0] ax;
        logic                      shock;
    } sample_t;

    typedef struct {
        logic                       slope_ok;
        logic signed [TREND_W-1:0]  tx;
        logic signed [TREND_W-1:0]  ty;
        logic signed [TREND_W-1:0]  tz;
        logic signed [TTREND_W-1:0] tt;
        logic [LEVEL_W-1:0]         level;
    } trend_res_t;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports; every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;
    logic                  cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = CFG_Z_LIMIT;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    sliding_trend_slope_alarm u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    sample_t    pending_samples[$];   // words still to be offered
    trend_res_t trend_queue[$];       // predicted results, oldest first
    sample_t    cur_word;             // word currently on the input bus

    // Window model: one row per channel, plus the saturating fill level.
    int                sample_hist[4][WIN];
    int                fill_level = 0;
    logic [ZLIM_W-1:0] z_limit    = Z_LIMIT_RESET;
    logic [TLIM_W-1:0] t_limit    = TEMP_LIMIT_RESET;

    bit idle_en = 1'b1;   // cleared for the last part of the run
    int gap_left;
    int stall_left;
    int hold_left;
    bit hold_done;

    int cycle_count    = 0;
    int mismatch_count = 0;
    int words_sent     = 0;
    int words_checked  = 0;
    int warnings_seen  = 0;
    int shocks_seen    = 0;
    int settings_run   = 1;

    // ------------------------------------------------------------------------
    // Predictor: slide the window and form the exact trend numerators.
    // ------------------------------------------------------------------------
    function automatic trend_res_t predict_trend(input sample_t s);
        trend_res_t r;
        int         v[4];
        longint     acc[4];
        int         c;
        int         i;
        r   = '{default: '0};
        acc = '{default: 0};
        v[CH_X] = int'(s.ax);
        v[CH_Y] = int'(s.ay);
        v[CH_Z] = int'(s.az);
        v[CH_T] = int'(s.temp);
        if (fill_level < WIN) begin
            // still filling: store in place, trends stay zero
            for (c = 0; c < 4; c++) sample_hist[c][fill_level] = v[c];
            fill_level++;
        end else begin
            for (c = 0; c < 4; c++) begin
                for (i = 0; i < WIN - 1; i++) sample_hist[c][i] = sample_hist[c][i + 1];
                sample_hist[c][WIN - 1] = v[c];
                for (i = 0; i < WIN; i++)
                    acc[c] += longint'(WIN * i - POS_MID) * longint'(sample_hist[c][i]);
            end
            r.slope_ok = 1'b1;
            r.tx = acc[CH_X][TREND_W-1:0];
            r.ty = acc[CH_Y][TREND_W-1:0];
            r.tz = acc[CH_Z][TREND_W-1:0];
            r.tt = acc[CH_T][TTREND_W-1:0];
        end
        // The limit compare uses the full numerator, not the field value.
        if (s.shock)
            r.level = LVL_SHOCK;
        else if (r.slope_ok && (acc[CH_Z] > longint'(z_limit) || acc[CH_T] > longint'(t_limit)))
            r.level = LVL_WARNING;
        else
            r.level = LVL_NOMINAL;
        return r;
    endfunction

    task automatic log_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic signed [31:0] got,
                               input logic signed [31:0] want);
        if (got !== want)
            log_mismatch($sformatf("word %0d %s got %0d expected %0d",
                                   words_checked, name, got, want));
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int sat(input int v, input int lo, input int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function automatic sample_t make_sample(input int x, input int y, input int z,
                                            input int t, input bit shock);
        sample_t s;
        s.ax    = ACCEL_W'(sat(x, -32768, 32767));
        s.ay    = ACCEL_W'(sat(y, -32768, 32767));
        s.az    = ACCEL_W'(sat(z, -32768, 32767));
        s.temp  = TEMP_W'(sat(t, -128, 127));
        s.shock = shock;
        return s;
    endfunction

    function automatic int pick_edge(input int lo, input int hi);
        case ($urandom_range(0, 3))
            0: return lo;
            1: return hi;
            2: return 0;
            default: return -1;
        endcase
    endfunction

    // Push WIN words with the extreme value pattern, in reverse order when flip is set:
    // half the window at one rail, half at the other, for the largest trends.
    task automatic add_rail_step(input bit flip);
        int k;
        for (k = 0; k < WIN; k++) begin
            if ((k < WIN / 2) ^ flip)
                pending_samples.push_back(make_sample(-32768, -32768, -32768, -128, 1'b0));
            else
                pending_samples.push_back(make_sample(32767, 32767, 32767, 127, 1'b0));
        end
    endtask

    // Noisy linear ramps on every channel, the usual shape of a real trend.
    task automatic add_ramp(input int len);
        int bx, by, bz, bt;
        int sx, sy, sz, st;
        int k;
        bx = int'($urandom_range(0, 65535)) - 32768;
        by = int'($urandom_range(0, 65535)) - 32768;
        bz = int'($urandom_range(0, 40000)) - 20000;
        bt = int'($urandom_range(0, 200)) - 100;
        sx = int'($urandom_range(0, 4000)) - 2000;
        sy = int'($urandom_range(0, 200)) - 100;
        sz = int'($urandom_range(0, 80)) - 40;
        st = int'($urandom_range(0, 8)) - 4;
        for (k = 0; k < len; k++)
            pending_samples.push_back(make_sample(
                bx + sx * k + int'($urandom_range(0, 16)) - 8,
                by + sy * k + int'($urandom_range(0, 16)) - 8,
                bz + sz * k + int'($urandom_range(0, 16)) - 8,
                bt + st * k + int'($urandom_range(0, 2)) - 1,
                $urandom_range(0, 9) == 0));
    endtask

    // Mostly ramps, the rest raw random words and rail values.
    task automatic add_mix(input int n);
        int          queued;
        int          len;
        int          kind;
        logic [63:0] rnd;
        sample_t     s;
        queued = 0;
        while (queued < n) begin
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                len = $urandom_range(WIN, 30);
                add_ramp(len);
                queued += len;
            end else if (kind < 85) begin
                rnd = {$urandom(), $urandom()};
                s   = rnd[$bits(sample_t)-1:0];
                pending_samples.push_back(s);
                queued++;
            end else begin
                pending_samples.push_back(make_sample(pick_edge(-32768, 32767),
                    pick_edge(-32768, 32767), pick_edge(-32768, 32767),
                    pick_edge(-128, 127), 1'($urandom_range(0, 1))));
                queued++;
            end
        end
    endtask

    // Wait until the block has nothing in flight.
    task automatic wait_drained();
        while (pending_samples.size() != 0 || s_tvalid || trend_queue.size() != 0)
            @(posedge aclk);
    endtask

    // Write both limits; the temperature write may carry junk above its width.
    task automatic set_limits(input logic [ZLIM_W-1:0] z, input logic [CFG_DATA_W-1:0] t_raw);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_Z_LIMIT;
        cfg_wdata <= z;
        z_limit    = z;
        @(posedge aclk);
        cfg_addr  <= CFG_TEMP_LIMIT;
        cfg_wdata <= t_raw;
        t_limit    = t_raw[TLIM_W-1:0];
        @(posedge aclk);
        cfg_we    <= 1'b0;
        settings_run++;
    endtask

    // ------------------------------------------------------------------------
    // Sample driver: offer queued words, hold until taken, idle in bursts.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left  = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                trend_queue.push_back(predict_trend(cur_word));
                words_sent++;
            end
            if (s_tvalid && !s_tready) begin
                // hold the word until the block takes it
            end else if (gap_left > 0) begin
                s_tvalid <= 1'b0;
                gap_left--;
            end else if (idle_en && ((words_sent / 64) % 4 != 3) &&
                         pending_samples.size() != 0 && $urandom_range(0, 99) < 25) begin
                // start an idle burst
                s_tvalid <= 1'b0;
                gap_left  = $urandom_range(0, 18);
            end else if (pending_samples.size() != 0) begin
                cur_word  = pending_samples.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {cur_word.temp, cur_word.az, cur_word.ay, cur_word.ax};
                s_tuser  <= cur_word.shock;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result ready: random stall bursts, plus one long hold early in the run
    // so the output register and the work slot fill and s_tready drops.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
            hold_done  = 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (!hold_done && words_sent >= 40) begin
            m_tready <= 1'b0;
            hold_left = LONG_HOLD - 1;
            hold_done = 1'b1;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else if (idle_en && ((words_checked / 64) % 4 != 1) && $urandom_range(0, 99) < 20) begin
            m_tready  <= 1'b0;
            stall_left = $urandom_range(0, 18);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: compare each accepted word with the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : result_check
        trend_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (trend_queue.size() == 0) begin
                log_mismatch("result word with no prediction waiting");
            end else begin
                want = trend_queue.pop_front();
                check_field("slope_valid", 32'(m_tuser), 32'(want.slope_ok));
                check_field("trend_x", 32'($signed(m_tdata[TX_LO +: TREND_W])), 32'(want.tx));
                check_field("trend_y", 32'($signed(m_tdata[TY_LO +: TREND_W])), 32'(want.ty));
                check_field("trend_z", 32'($signed(m_tdata[TZ_LO +: TREND_W])), 32'(want.tz));
                check_field("trend_temp", 32'($signed(m_tdata[TT_LO +: TTREND_W])),
                            32'(want.tt));
                check_field("alarm_level", 32'(m_tdata[LV_LO +: LEVEL_W]), 32'(want.level));
                if (want.level == LVL_WARNING) warnings_seen++;
                if (want.level == LVL_SHOCK) shocks_seen++;
            end
            words_checked++;
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d predictions outstanding",
                     cycle_count, trend_queue.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int k;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed, reset limits. Fill the window with rail values, shock on
        // and off, and a short ramp; the word that completes it still has zero trends.
        pending_samples.push_back(make_sample(32767, -32768, 0, 127, 1'b1));
        pending_samples.push_back(make_sample(-32768, 32767, -1, -128, 1'b0));
        pending_samples.push_back(make_sample(0, 0, 0, 0, 1'b0));
        pending_samples.push_back(make_sample(-1, -1, -1, -1, 1'b1));
        for (k = 4; k < WIN; k++)
            pending_samples.push_back(make_sample(100 * k, -100 * k, 50 * k, k, 1'b0));
        // First slides, up to the largest positive trend on every channel; then a shock word.
        add_rail_step(1'b0);
        pending_samples.push_back(make_sample(32767, 32767, 32767, 127, 1'b1));
        wait_drained();

        // Zero limits: any rising z or temperature trend warns.
        set_limits('0, '0);
        add_mix(430);
        wait_drained();

        // Limits at full register width: no trend can warn; most negative trends.
        set_limits({ZLIM_W{1'b1}}, {{(CFG_DATA_W - TLIM_W){1'b0}}, {TLIM_W{1'b1}}});
        add_rail_step(1'b1);
        add_mix(430);
        wait_drained();

        // Limits just above the largest trends a full-rail window can reach.
        set_limits(24'd14155776, 24'd55296);
        add_rail_step(1'b0);
        add_mix(430);
        wait_drained();

        // Mid-range limits with junk above the temperature width; no idling.
        set_limits(ZLIM_W'($urandom_range(0, 20000)),
                   {8'($urandom()), 16'($urandom_range(0, 6000))});
        idle_en = 1'b0;
        add_mix(430);
        wait_drained();

        repeat (WIN + 10) @(posedge aclk);
        if (trend_queue.size() != 0)
            log_mismatch($sformatf("%0d predictions never matched", trend_queue.size()));

        $display("Ran %0d samples through %0d limit settings, checked %0d result words",
                 words_sent, settings_run, words_checked);
        $display("(%0d trend warnings, %0d shock alerts, %0d mismatches)",
                 warnings_seen, shocks_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
